// File: hw/rtl/mpm_pkg.sv
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared constants and controller/datapath interface types for the
// magnitude pruning mask block.
// ----------------------------------------------------------------------------
package mpm_pkg;

  localparam int DEF_MAX_WEIGHTS = 4096;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int RATIO_W = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    logic accept_load;
    logic accept_read;
    logic calc_k;
    logic init_search;
    logic zero_thresh;
    logic scan_begin;
    logic scan_run;
    logic scan_prune;
    logic search_update;
    logic set_thresh;
    logic finish_set;
    logic out_summary;
    logic out_read;
  } mpm_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic search_done;
    logic scan_done;
    logic out_free;
  } mpm_sts_t;

endpackage

// File: hw/rtl/mpm_ctrl.sv
// ----------------------------------------------------------------------------
// mpm_ctrl
// Sequencer: accepts items, runs the threshold search passes and the
// pruned-count pass over the store, and schedules result transfers.
// ----------------------------------------------------------------------------
module mpm_ctrl import mpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     opcode,
  input  logic     last_weight,
  input  mpm_sts_t sts,
  output logic     in_ready,
  output mpm_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KCALC,
    S_KCHECK,
    S_SEARCH,
    S_LE_SCAN,
    S_PR_SCAN,
    S_SUMMARY,
    S_RD_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_LOAD) begin
            cmd.accept_load = 1'b1;
            if (last_weight) state_next = S_KCALC;
          end else begin
            cmd.accept_read = 1'b1;
            state_next = S_RD_OUT;
          end
        end
      end
      S_KCALC: begin
        cmd.calc_k = 1'b1;
        state_next = S_KCHECK;
      end
      S_KCHECK: begin
        if (sts.k_zero) begin
          cmd.zero_thresh = 1'b1;
          cmd.scan_begin = 1'b1;
          state_next = S_PR_SCAN;
        end else begin
          cmd.init_search = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.scan_begin = 1'b1;
        if (sts.search_done) begin
          cmd.set_thresh = 1'b1;
          state_next = S_PR_SCAN;
        end else begin
          state_next = S_LE_SCAN;
        end
      end
      S_LE_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_run = 1'b0;
          cmd.search_update = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_PR_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.scan_prune = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_run = 1'b0;
          cmd.finish_set = 1'b1;
          state_next = S_SUMMARY;
        end
      end
      S_SUMMARY: begin
        if (sts.out_free) begin
          cmd.out_summary = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_OUT: begin
        cmd.scan_prune = 1'b1;
        if (sts.out_free) begin
          cmd.out_read = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/mpm_datapath.sv
// ----------------------------------------------------------------------------
// mpm_datapath
// Weight store, set bookkeeping, percentile search registers, the store
// scan counter and the result register.
// ----------------------------------------------------------------------------
module mpm_datapath import mpm_pkg::*; #(
  parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  localparam int IDX_W = $clog2(MAX_WEIGHTS),
  localparam int CNT_W = $clog2(MAX_WEIGHTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpm_cmd_t                      cmd,
  output mpm_sts_t                      sts,
  input  logic                          cfg_valid,
  input  logic [RATIO_W-1:0]            prune_ratio,
  input  logic signed [WEIGHT_BITS-1:0] weight_value,
  input  logic [IDX_W-1:0]              entry_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [WEIGHT_BITS-1:0]        threshold,
  output logic [CNT_W-1:0]              pruned_count,
  output logic [CNT_W-1:0]              weight_total,
  output logic                          keep,
  output logic signed [WEIGHT_BITS-1:0] pruned_weight,
  output logic                          read_error
);

  localparam int PROD_W = CNT_W + RATIO_W;

  logic signed [WEIGHT_BITS-1:0] mem [MAX_WEIGHTS];
  logic signed [WEIGHT_BITS-1:0] mem_q;

  logic [CNT_W-1:0]       count;
  logic [RATIO_W-1:0]     ratio;
  logic [CNT_W-1:0]       k;
  logic [WEIGHT_BITS-1:0] lo;
  logic [WEIGHT_BITS-1:0] hi;
  logic [WEIGHT_BITS-1:0] thr;
  logic                   pct;
  logic                   set_ready;
  logic [CNT_W-1:0]       scan_addr;
  logic [CNT_W-1:0]       acc;
  logic                   rd_v;
  logic                   err_r;

  logic [WEIGHT_BITS-1:0] mid;
  logic [WEIGHT_BITS-1:0] mag_q;
  logic                   prune_hit;
  logic                   le_hit;
  logic                   hit;
  logic                   full;
  logic                   scan_issue;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_en;
  logic [RATIO_W-1:0]     ratio_sat;
  logic [PROD_W-1:0]      prod;
  logic                   out_free;

  assign mid = lo + ((hi - lo) >> 1);
  // The most negative weight has a magnitude that still fits unsigned.
  assign mag_q = mem_q[WEIGHT_BITS-1] ? (~mem_q + 1'b1) : mem_q;
  assign prune_hit = pct ? (mag_q <= thr) : (mem_q == '0);
  assign le_hit = (mag_q <= mid);
  assign hit = cmd.scan_prune ? prune_hit : le_hit;

  assign full = (count == CNT_W'(MAX_WEIGHTS));
  assign wr_en = cmd.accept_load && (set_ready || !full);
  assign wr_addr = set_ready ? '0 : count[IDX_W-1:0];

  assign scan_issue = cmd.scan_run && (scan_addr != count);
  assign rd_en = scan_issue || cmd.accept_read;
  assign rd_addr = cmd.accept_read ? entry_index : scan_addr[IDX_W-1:0];

  assign ratio_sat = (ratio > RATIO_ONE) ? RATIO_ONE : ratio;
  assign prod = PROD_W'(count) * PROD_W'(ratio_sat);

  assign out_free = !out_valid || out_ready;

  assign sts.k_zero = (k == '0);
  assign sts.search_done = (lo >= hi);
  assign sts.scan_done = (scan_addr == count) && !rd_v;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= weight_value;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ratio <= '0;
      thr <= '0;
      pct <= 1'b0;
      set_ready <= 1'b0;
      rd_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) ratio <= prune_ratio;
      rd_v <= scan_issue;
      if (cmd.accept_load) begin
        if (set_ready) begin
          count <= CNT_W'(1);
          thr <= '0;
          pct <= 1'b0;
          set_ready <= 1'b0;
        end else if (!full) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.zero_thresh) begin
        thr <= '0;
        pct <= 1'b0;
      end
      if (cmd.init_search) pct <= 1'b1;
      if (cmd.set_thresh) thr <= lo;
      if (cmd.finish_set) set_ready <= 1'b1;
      if (cmd.out_summary || cmd.out_read) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_k) k <= CNT_W'(prod >> FRAC_BITS);
    if (cmd.init_search) begin
      lo <= '0;
      hi <= WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);
    end
    if (cmd.search_update) begin
      if (acc >= k) begin
        hi <= mid;
      end else begin
        lo <= mid + 1'b1;
      end
    end
    if (cmd.scan_begin) begin
      scan_addr <= '0;
      acc <= '0;
    end else begin
      if (scan_issue) scan_addr <= scan_addr + 1'b1;
      if (rd_v && hit) acc <= acc + 1'b1;
    end
    if (cmd.accept_read) begin
      err_r <= !set_ready || (CNT_W'(entry_index) >= count);
    end
    if (cmd.out_summary) begin
      result_kind <= KIND_SUMMARY;
      threshold <= thr;
      pruned_count <= acc;
      weight_total <= count;
      keep <= 1'b0;
      pruned_weight <= '0;
      read_error <= 1'b0;
    end else if (cmd.out_read) begin
      result_kind <= KIND_READOUT;
      threshold <= '0;
      pruned_count <= '0;
      weight_total <= '0;
      keep <= !err_r && !prune_hit;
      pruned_weight <= (!err_r && !prune_hit) ? mem_q : '0;
      read_error <= err_r;
    end
  end

endmodule

// File: hw/rtl/magnitude_prune_mask.sv
// A read's result is registered in the readout state once the output is free. Closing a set
// stalls input for the k calculation and check, up to WEIGHT_BITS bisection steps (none
// when k is 0) and the pruned-count pass; each search step is one pass over the single-port store.
// The summary is valid as input reopens. Throughput: one load per cycle while input is open;
// a read holds input until its result is issued. Reset (rst, synchronous, active high)
// clears control, count and ratio; the store is left as is.
// ----------------------------------------------------------------------------
// magnitude_prune_mask
// Magnitude pruning with a percentile threshold found by bisection over the
// stored weights, followed by per-entry keep/pruned readout.
// ----------------------------------------------------------------------------
module magnitude_prune_mask import mpm_pkg::*; #(
  parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  localparam int IDX_W = $clog2(MAX_WEIGHTS),
  localparam int CNT_W = $clog2(MAX_WEIGHTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [RATIO_W-1:0]            prune_ratio,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic signed [WEIGHT_BITS-1:0] weight_value,
  input  logic                          last_weight,
  input  logic [IDX_W-1:0]              entry_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [WEIGHT_BITS-1:0]        threshold,
  output logic [CNT_W-1:0]              pruned_count,
  output logic [CNT_W-1:0]              weight_total,
  output logic                          keep,
  output logic signed [WEIGHT_BITS-1:0] pruned_weight,
  output logic                          read_error
);

  mpm_cmd_t cmd;
  mpm_sts_t sts;

  assign cfg_ready = 1'b1;

  mpm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .opcode     (opcode),
    .last_weight(last_weight),
    .sts        (sts),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  mpm_datapath #(
    .MAX_WEIGHTS(MAX_WEIGHTS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .prune_ratio  (prune_ratio),
    .weight_value (weight_value),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .threshold    (threshold),
    .pruned_count (pruned_count),
    .weight_total (weight_total),
    .keep         (keep),
    .pruned_weight(pruned_weight),
    .read_error   (read_error)
  );

endmodule

// File: hw/rtl/mpm_checker.sv
// ----------------------------------------------------------------------------
// mpm_checker
// Port-level checks for the magnitude pruning mask block, bound to the top.
// ----------------------------------------------------------------------------
module mpm_checker import mpm_pkg::*; #(
  parameter int MAX_WEIGHTS = DEF_MAX_WEIGHTS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  localparam int IDX_W = $clog2(MAX_WEIGHTS),
  localparam int CNT_W = $clog2(MAX_WEIGHTS + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          opcode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          result_kind,
  input logic [CNT_W-1:0]              pruned_count,
  input logic [CNT_W-1:0]              weight_total,
  input logic                          keep,
  input logic signed [WEIGHT_BITS-1:0] pruned_weight,
  input logic                          read_error
);

  // A result waiting for transfer holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pruned_weight) && $stable(keep))
    else $error("result changed while stalled");

  a_summary_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_SUMMARY |->
      !keep && !read_error && pruned_count <= weight_total && weight_total != '0)
    else $error("malformed summary");

  a_readout_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_READOUT && !keep |-> pruned_weight == '0)
    else $error("pruned entry carries a weight");

  // A read transfer blocks input until its readout is produced.
  a_read_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_READ |=> !in_ready)
    else $error("input taken during readout");

endmodule

bind magnitude_prune_mask mpm_checker #(
  .MAX_WEIGHTS(MAX_WEIGHTS),
  .WEIGHT_BITS(WEIGHT_BITS)
) u_mpm_checker (.*);

// File: tb/sv/tb_magnitude_prune_mask.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_magnitude_prune_mask
// Drives weight sets and entry reads into the pruning block and checks every summary
// and readout against a behavioral threshold predictor; typed reads expect an error.
// ----------------------------------------------------------------------------
module tb_magnitude_prune_mask;
  import mpm_pkg::*;

  localparam int NW = DEF_MAX_WEIGHTS;

  typedef struct {
    logic        op;
    logic [15:0] wval;
    logic        last;
    logic [11:0] idx;
    bit          typed;
  } item_t;

  typedef struct {
    logic        kind;
    logic [15:0] thr;
    logic [12:0] pcnt;
    logic [12:0] total;
    logic        keep;
    logic [15:0] pw;
    logic        err;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RATIO_W-1:0] prune_ratio = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_LOAD;
  logic signed [15:0] weight_value = '0;
  logic last_weight = 1'b0;
  logic [11:0] entry_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic result_kind;
  logic [15:0] threshold;
  logic [12:0] pruned_count;
  logic [12:0] weight_total;
  logic keep;
  logic signed [15:0] pruned_weight;
  logic read_error;

  magnitude_prune_mask dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .prune_ratio(prune_ratio),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .weight_value(weight_value), .last_weight(last_weight), .entry_index(entry_index),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .threshold(threshold), .pruned_count(pruned_count), .weight_total(weight_total),
    .keep(keep), .pruned_weight(pruned_weight), .read_error(read_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic signed [15:0] wstore [NW];
  int unsigned n_loaded;
  logic [16:0] cur_thr;
  bit pct_used;
  bit set_done;
  int unsigned sum_pruned;
  logic [RATIO_W-1:0] ratio_reg;

  res_t expected_q [$];
  int errors = 0;
  int burst_left = 0;
  bit squeeze = 0;

  function automatic logic [16:0] mag(logic signed [15:0] w);
    return w < 0 ? 17'(-int'(w)) : 17'(w);
  endfunction

  function automatic bit survives(logic signed [15:0] w);
    return pct_used ? (mag(w) > cur_thr) : (w != 0);
  endfunction

  function automatic int unsigned count_at_most(logic [16:0] v);
    int unsigned c = 0;
    for (int i = 0; i < n_loaded; i++)
      if (mag(wstore[i]) <= v) c++;
    return c;
  endfunction

  function automatic void close_set();
    longint unsigned r, k;
    logic [16:0] lo, hi, mid;
    r = ratio_reg > RATIO_ONE ? 65536 : ratio_reg;
    k = (longint'(n_loaded) * r) >> FRAC_BITS;
    if (k > 0) begin
      // Smallest magnitude with at least k weights at or below it.
      lo = 0;
      hi = 17'd32768;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (count_at_most(mid) >= k) hi = mid;
        else lo = mid + 1;
      end
      cur_thr = lo;
      pct_used = 1;
    end else begin
      cur_thr = 0;
      pct_used = 0;
    end
    sum_pruned = 0;
    for (int i = 0; i < n_loaded; i++)
      if (!survives(wstore[i])) sum_pruned++;
    set_done = 1;
  endfunction

  function automatic bit predict_mask(item_t it, output res_t r);
    r = '{default: '0};
    if (it.op == OP_LOAD) begin
      if (set_done) begin
        n_loaded = 0; cur_thr = 0; pct_used = 0; sum_pruned = 0; set_done = 0;
      end
      if (n_loaded < NW) begin
        wstore[n_loaded] = it.wval;
        n_loaded++;
      end
      if (!it.last) return 0;
      close_set();
      r.kind = KIND_SUMMARY;
      r.thr = cur_thr[15:0];
      r.pcnt = 13'(sum_pruned);
      r.total = 13'(n_loaded);
      return 1;
    end
    r.kind = KIND_READOUT;
    if (!set_done || it.idx >= n_loaded) r.err = 1;
    else if (survives(wstore[it.idx])) begin
      r.keep = 1;
      r.pw = wstore[it.idx];
    end
    return 1;
  endfunction

  task automatic send_item(item_t it, res_t typed_res);
    res_t r;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    opcode = it.op;
    weight_value = it.wval;
    last_weight = it.last;
    entry_index = it.idx;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (predict_mask(it, r)) expected_q.push_back(it.typed ? typed_res : r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_ratio(logic [RATIO_W-1:0] v);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_valid = 1'b1;
    prune_ratio = v;
    do @(posedge clk); while (!cfg_ready);
    ratio_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic item_t load_of(logic [15:0] w, logic l);
    return '{op: OP_LOAD, wval: w, last: l, idx: 12'($urandom), typed: 0};
  endfunction

  function automatic item_t read_of(logic [11:0] i);
    return '{op: OP_READ, wval: 16'($urandom), last: 1'($urandom), idx: i, typed: 0};
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return 16'($signed($urandom_range(0, 12)) - 6);
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: shifting stall pattern, plus one long hold-off on request.
  initial begin
    int cyc = 0;
    int hold = 0;
    bit held = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (squeeze && !held) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        case ((cyc / 97) % 3)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom);
          default: out_ready = (cyc % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0b", $time, result_kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result_kind !== e.kind || threshold !== e.thr || pruned_count !== e.pcnt ||
            weight_total !== e.total || keep !== e.keep || pruned_weight !== e.pw ||
            read_error !== e.err) begin
          $display("%0t: mismatch expected kind=%0b thr=%0d pruned=%0d total=%0d keep=%0b w=%0d err=%0b",
                   $time, e.kind, e.thr, e.pcnt, e.total, e.keep, $signed(e.pw), e.err);
          $display("%0t:          actual kind=%0b thr=%0d pruned=%0d total=%0d keep=%0b w=%0d err=%0b",
                   $time, result_kind, threshold, pruned_count, weight_total, keep,
                   pruned_weight, read_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    item_t table_rows [$];
    res_t typed_res [$];
    res_t err_read;
    res_t none;
    item_t it;
    int sent;
    int n;
    bit full_done;
    logic [RATIO_W-1:0] ratios [6];

    n_loaded = 0; cur_thr = 0; pct_used = 0; set_done = 0; sum_pruned = 0; ratio_reg = 0;
    err_read = '{kind: KIND_READOUT, err: 1'b1, default: '0};
    none = '{default: '0};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part: read before any summary, extremes, ties, new set, range checks.
    it = read_of(12'd0); it.typed = 1; table_rows.push_back(it); typed_res.push_back(err_read);
    foreach (ratios[i]) ratios[i] = 0;
    table_rows.push_back(load_of(16'h8000, 0));
    table_rows.push_back(load_of(16'h7fff, 0));
    table_rows.push_back(load_of(16'h0000, 0));
    table_rows.push_back(load_of(16'h0001, 0));
    table_rows.push_back(load_of(16'hffff, 0));
    table_rows.push_back(load_of(16'h0005, 1));
    for (int i = 0; i < 6; i++) table_rows.push_back(read_of(12'(i)));
    it = read_of(12'hfff); it.typed = 1; table_rows.push_back(it);
    table_rows.push_back(load_of(16'h0007, 0));
    it = read_of(12'd0); it.typed = 1; table_rows.push_back(it);
    table_rows.push_back(load_of(16'hfff9, 1));
    table_rows.push_back(read_of(12'd1));
    table_rows.push_back(read_of(12'd2));
    while (typed_res.size() < table_rows.size()) typed_res.push_back(err_read);

    write_ratio(17'd32768);
    foreach (table_rows[i]) send_item(table_rows[i], typed_res[i]);

    ratios[0] = 0;
    ratios[1] = RATIO_ONE;
    ratios[2] = 17'h1ffff;
    ratios[3] = 17'd1;
    ratios[4] = 17'd49152;
    sent = 0;
    full_done = 0;
    while (sent < 1900 || !full_done) begin
      ratios[5] = 17'($urandom_range(0, 70000));
      write_ratio(ratios[$urandom_range(0, 5)]);
      if (sent > 400 && !full_done) begin
        n = NW + 4;
        full_done = 1;
      end else if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 300);
      else n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        send_item(load_of(rand_weight(), i == n - 1), none);
        if (n < 300 && $urandom_range(0, 15) == 0)
          send_item(read_of(12'($urandom_range(0, n))), none);
      end
      if (sent > 200) squeeze = 1;
      for (int i = 0; i < (n > 300 ? 600 : n + 3); i++) begin
        if ($urandom_range(0, 7) == 0) send_item(read_of(12'($urandom)), none);
        else send_item(read_of(12'($urandom_range(0, n > NW ? NW - 1 : n - 1))), none);
        sent++;
      end
      sent += n;
    end

    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
